FILE: rtl/isbc_pkg.sv
// ----------------------------------------------------------------------------
// isbc_pkg: shared definitions for the IMU stillness bias calibration block
// Sample and register widths, reset values, register indexes and the
// pipeline item that carries one six-axis sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isbc_pkg;

  localparam int SAMPLE_W          = 16;
  localparam int NUM_AXES          = 6;
  localparam int STILL_SAMPLES_DEF = 400;

  localparam int THR_W      = 16;
  localparam int GRAV_W     = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd50;
  localparam logic [GRAV_W-1:0] GRAVITY_RST   = 15'd16384;

  localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_COUNTS  = 1'd1;

  // Axis order: accel x, y, z, then gyro x, y, z.
  localparam int AX_ACCEL_Z = 2;
  localparam int AX_GYRO_X  = 3;

  typedef struct packed {
    logic [NUM_AXES-1:0][SAMPLE_W-1:0] axis;
    logic                              still;
    logic                              cal;
  } item_t;

endpackage

FILE: rtl/isbc_div.sv
// ----------------------------------------------------------------------------
// isbc_div: signed sum to per-axis offset, divide by the sample count
// Three registered steps: magnitude, multiply by a reciprocal, sign restore.
// Truncates toward zero; exact over the full range of the running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isbc_div #(
  parameter int STILL_SAMPLES = isbc_pkg::STILL_SAMPLES_DEF
) (
  input  logic                                                      clk,
  input  logic signed [isbc_pkg::SAMPLE_W+$clog2(STILL_SAMPLES)-1:0] sum,
  output logic signed [isbc_pkg::SAMPLE_W-1:0]                      offset
);
  import isbc_pkg::*;

  localparam int CL    = $clog2(STILL_SAMPLES);
  localparam int SUMW  = SAMPLE_W + CL;
  localparam int SHIFT = SUMW + CL;
  localparam int RW    = SUMW + 1;
  localparam int PW    = SUMW + RW;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(STILL_SAMPLES) - 64'd1) / 64'(STILL_SAMPLES);
  localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

  logic            [SUMW-1:0]     mag;
  logic                           neg_mag;
  logic            [PW-1:0]       prod;
  logic                           neg_prod;
  logic            [SAMPLE_W-1:0] quot;

  assign quot = prod[SHIFT+SAMPLE_W-1:SHIFT];

  always_ff @(posedge clk) begin
    neg_mag  <= sum[SUMW-1];
    mag      <= sum[SUMW-1] ? (~sum + 1'b1) : sum;
    neg_prod <= neg_mag;
    prod     <= PW'(mag) * PW'(RECIP);
    offset   <= neg_prod ? (~quot + 1'b1) : quot;
  end

endmodule

FILE: rtl/imu_stillness_bias_calibration.sv
// ----------------------------------------------------------------------------
// imu_stillness_bias_calibration: six-axis accel/gyro bias removal
// Learns per-axis offsets from a run of still samples after reset and
// subtracts them from calibration on; gravity_counts is always added onto accel z.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one six-axis sample per
//   transaction; output channel (out_valid / out_stall) returns one
//   corrected sample per transaction, in order, with is_calibrated.
//   Config channel (cfg_valid / cfg_ready, always ready) writes
//   still_threshold (index 0) and gravity_counts (index 1); write it
//   only while no sample is in flight.
//   An accepted sample passes through stages 0 to 4 and then the output
//   register. Throughput: one sample per cycle while out_stall is low. The
//   depth is set by the three-step offset divider that must finish before
//   the sample that completes calibration reaches the output subtract.
//   Reset clears the pipeline, sums and count, and restores the register
//   defaults; calibration then starts over.
//   When the receiver stalls, the output holds; each stage keeps filling
//   bubbles and in_stall rises only once the whole pipeline is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_stillness_bias_calibration #(
  parameter int STILL_SAMPLES = isbc_pkg::STILL_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [isbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [isbc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [isbc_pkg::SAMPLE_W-1:0] raw_accel_x,
  input  logic signed [isbc_pkg::SAMPLE_W-1:0] raw_accel_y,
  input  logic signed [isbc_pkg::SAMPLE_W-1:0] raw_accel_z,
  input  logic signed [isbc_pkg::SAMPLE_W-1:0] raw_gyro_x,
  input  logic signed [isbc_pkg::SAMPLE_W-1:0] raw_gyro_y,
  input  logic signed [isbc_pkg::SAMPLE_W-1:0] raw_gyro_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [isbc_pkg::SAMPLE_W-1:0] corrected_accel_x,
  output logic signed [isbc_pkg::SAMPLE_W-1:0] corrected_accel_y,
  output logic signed [isbc_pkg::SAMPLE_W-1:0] corrected_accel_z,
  output logic signed [isbc_pkg::SAMPLE_W-1:0] corrected_gyro_x,
  output logic signed [isbc_pkg::SAMPLE_W-1:0] corrected_gyro_y,
  output logic signed [isbc_pkg::SAMPLE_W-1:0] corrected_gyro_z,
  output logic                                 is_calibrated
);
  import isbc_pkg::*;

  localparam int CL   = $clog2(STILL_SAMPLES);
  localparam int SUMW = SAMPLE_W + CL;
  localparam int CW   = CL;
  localparam int DW   = SAMPLE_W + 2;  // gyro difference plus headroom for compare
  // Stage 0 holds the accepted sample; the move into stage 1 updates the
  // calibration state. Stages 1..4 cover the divider latency.
  localparam int NST  = 5;

  // Configuration registers
  logic [THR_W-1:0]  still_threshold;
  logic [GRAV_W-1:0] gravity_counts;

  // Calibration state
  logic [2:0][SAMPLE_W-1:0] previous_gyro;
  logic [CW-1:0]            still_count;
  logic                     calibrated;
  logic signed [SUMW-1:0]   sums [NUM_AXES];
  logic signed [SAMPLE_W-1:0] offsets [NUM_AXES];

  // Pipeline
  item_t          st [NST];
  logic [NST-1:0] v;
  logic [NST-1:0] rdy;
  logic           out_rdy;
  logic           in_acc;
  logic           move0;
  logic           still_in;
  logic           completing;
  item_t          in_item;
  item_t          st1_next;
  logic [NUM_AXES-1:0][SAMPLE_W-1:0] result;

  assign cfg_ready = 1'b1;
  assign out_rdy   = !out_valid || !out_stall;

  // Ready ripples back from the output register; a stage takes a new item
  // when it is empty or its current item moves on.
  always_comb begin
    rdy[NST-1] = !v[NST-1] || out_rdy;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];
  assign in_acc   = in_valid && rdy[0];
  assign move0    = v[0] && rdy[1];

  // Stillness test against the previous accepted sample: |d| < threshold
  // written as two compares to keep the path short.
  always_comb begin
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] thr;
    logic signed [SAMPLE_W-1:0] cur;
    logic signed [SAMPLE_W-1:0] prv;
    thr      = DW'({2'b00, still_threshold});
    still_in = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cur = (i == 0) ? raw_gyro_x : ((i == 1) ? raw_gyro_y : raw_gyro_z);
      prv = previous_gyro[i];
      d   = DW'(cur) - DW'(prv);
      if (!((d < thr) && (d > -thr))) begin
        still_in = 1'b0;
      end
    end
  end

  always_comb begin
    in_item.axis[0] = raw_accel_x;
    in_item.axis[1] = raw_accel_y;
    in_item.axis[2] = raw_accel_z;
    in_item.axis[3] = raw_gyro_x;
    in_item.axis[4] = raw_gyro_y;
    in_item.axis[5] = raw_gyro_z;
    in_item.still   = still_in;
    in_item.cal     = 1'b0;
  end

  // The sample that brings the run to STILL_SAMPLES closes calibration and
  // already carries the new offsets.
  assign completing = !calibrated && st[0].still && (still_count == CW'(STILL_SAMPLES - 1));

  always_comb begin
    st1_next     = st[0];
    st1_next.cal = calibrated || completing;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      still_threshold <= THRESHOLD_RST;
      gravity_counts  <= GRAVITY_RST;
      previous_gyro   <= '0;
      still_count     <= '0;
      calibrated      <= 1'b0;
      v               <= '0;
      out_valid       <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STILL_THRESHOLD: still_threshold <= cfg_data[THR_W-1:0];
          REG_GRAVITY_COUNTS:  gravity_counts  <= cfg_data[GRAV_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        previous_gyro[0] <= raw_gyro_x;
        previous_gyro[1] <= raw_gyro_y;
        previous_gyro[2] <= raw_gyro_z;
      end

      // Advance stage valids; a stage holds when it is full and blocked.
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (out_rdy) begin
        out_valid <= v[NST-1];
      end

      // Still run bookkeeping; frozen once calibrated.
      if (move0 && !calibrated) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          sums[i] <= st[0].still
                   ? sums[i] + {{CL{st[0].axis[i][SAMPLE_W-1]}}, st[0].axis[i]}
                   : '0;
        end
        if (completing) begin
          calibrated <= 1'b1;
        end else if (st[0].still) begin
          still_count <= still_count + 1'b1;
        end else begin
          still_count <= '0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st[0] <= in_item;
    end
    if (rdy[1]) begin
      st[1] <= st1_next;
    end
    for (int k = 2; k < NST; k++) begin
      if (rdy[k]) begin
        st[k] <= st[k-1];
      end
    end
  end

  // Offset dividers: free running on the sums, which freeze once calibrated.
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_div
    isbc_div #(
      .STILL_SAMPLES(STILL_SAMPLES)
    ) u_div (
      .clk   (clk),
      .sum   (sums[i]),
      .offset(offsets[i])
    );
  end

  // Subtract offsets (zero for items taken before calibration), add gravity.
  always_comb begin
    logic [SAMPLE_W-1:0] off;
    for (int i = 0; i < NUM_AXES; i++) begin
      off       = st[NST-1].cal ? offsets[i] : '0;
      result[i] = st[NST-1].axis[i] - off;
      if (i == AX_ACCEL_Z) begin
        result[i] = result[i] + {1'b0, gravity_counts};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && v[NST-1]) begin
      corrected_accel_x <= result[0];
      corrected_accel_y <= result[1];
      corrected_accel_z <= result[AX_ACCEL_Z];
      corrected_gyro_x  <= result[AX_GYRO_X];
      corrected_gyro_y  <= result[4];
      corrected_gyro_z  <= result[5];
      is_calibrated     <= st[NST-1].cal;
    end
  end

`ifndef ASSERT_OFF
  // Calibration never falls back once reached.
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    calibrated |=> calibrated)
    else $error("calibration flag dropped");

  // Run state moves only when a sample passes the update point.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !move0 |=> $stable(still_count) && $stable(calibrated))
    else $error("calibration state changed without a sample");

  // A calibrated result cannot leave before the block itself is calibrated.
  a_out_cal: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_calibrated |-> calibrated)
    else $error("calibrated result ahead of calibration");
`endif

endmodule

FILE: tb/sv/imu_stillness_bias_calibration_tb.sv
// ----------------------------------------------------------------------------
// imu_stillness_bias_calibration_tb: self-checking bench for bias calibration
// Streams six-axis samples through the block under random source gaps and
// sink stalls. Covers near-miss still runs, the run that locks the offsets,
// and frozen operation afterwards. Each corrected sample is checked field by
// field against an in-bench bias tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_stillness_bias_calibration_tb;
  import isbc_pkg::*;

  localparam int STILL_N     = STILL_SAMPLES_DEF;
  localparam int LATENCY     = 5;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TIMEOUT_NS  = 4_000_000;

  // One six-axis sample; axis 0..2 accel x/y/z, axis 3..5 gyro x/y/z.
  typedef struct packed {
    logic [NUM_AXES-1:0][SAMPLE_W-1:0] axis;
  } sample_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][SAMPLE_W-1:0] axis;
    logic                              cal;
  } correction_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic signed [SAMPLE_W-1:0]   raw_accel_x = '0;
  logic signed [SAMPLE_W-1:0]   raw_accel_y = '0;
  logic signed [SAMPLE_W-1:0]   raw_accel_z = '0;
  logic signed [SAMPLE_W-1:0]   raw_gyro_x  = '0;
  logic signed [SAMPLE_W-1:0]   raw_gyro_y  = '0;
  logic signed [SAMPLE_W-1:0]   raw_gyro_z  = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0]   corrected_accel_x;
  logic signed [SAMPLE_W-1:0]   corrected_accel_y;
  logic signed [SAMPLE_W-1:0]   corrected_accel_z;
  logic signed [SAMPLE_W-1:0]   corrected_gyro_x;
  logic signed [SAMPLE_W-1:0]   corrected_gyro_y;
  logic signed [SAMPLE_W-1:0]   corrected_gyro_z;
  logic                         is_calibrated;

  imu_stillness_bias_calibration #(.STILL_SAMPLES(STILL_N)) dut (.*);

  always #6 clk = ~clk;

  // Samples waiting for the source, and corrections waiting for the sink.
  sample_t     pending_samples [$];
  correction_t expected_corrections [$];

  // Bias tracker: register copies plus the block's calibration state.
  int   thr_model  = THRESHOLD_RST;
  int   grav_model = GRAVITY_RST;
  int   prev_gyro [3] = '{0, 0, 0};
  int   still_run = 0;
  int   accel_acc [3] = '{0, 0, 0};
  int   gyro_acc  [3] = '{0, 0, 0};
  int   accel_bias [3] = '{0, 0, 0};
  int   gyro_bias  [3] = '{0, 0, 0};
  logic bias_locked = 1'b0;

  int n_accepted  = 0;
  int n_checked   = 0;
  int fail_count  = 0;
  int lock_sample = -1;

  string axis_label [6] = '{"corrected_accel_x", "corrected_accel_y", "corrected_accel_z",
                            "corrected_gyro_x", "corrected_gyro_y", "corrected_gyro_z"};

  // Advance the bias tracker by one sample and return the corrected result.
  function automatic correction_t correct_sample(input sample_t s);
    correction_t r;
    int          v [6];
    int          d;
    logic        moving;
    for (int i = 0; i < 6; i++) v[i] = $signed(s.axis[i]);
    if (!bias_locked) begin
      moving = 1'b0;
      for (int i = 0; i < 3; i++) begin
        d = v[3+i] - prev_gyro[i];
        if (d < 0) d = -d;
        if (d >= thr_model) moving = 1'b1;
      end
      if (moving) begin
        // Any motion drops the run and its sums.
        still_run = 0;
        for (int i = 0; i < 3; i++) begin
          accel_acc[i] = 0;
          gyro_acc[i]  = 0;
        end
      end else begin
        still_run++;
        for (int i = 0; i < 3; i++) begin
          accel_acc[i] += v[i];
          gyro_acc[i]  += v[3+i];
        end
      end
      for (int i = 0; i < 3; i++) prev_gyro[i] = v[3+i];
      if (still_run >= STILL_N) begin
        // Division of int truncates toward zero, as the offsets require.
        for (int i = 0; i < 3; i++) begin
          accel_bias[i] = accel_acc[i] / STILL_N;
          gyro_bias[i]  = gyro_acc[i] / STILL_N;
        end
        bias_locked = 1'b1;
        lock_sample = n_accepted;
      end
    end
    r.axis[0] = 16'(v[0] - accel_bias[0]);
    r.axis[1] = 16'(v[1] - accel_bias[1]);
    r.axis[2] = 16'(v[2] - accel_bias[2] + grav_model);
    r.axis[3] = 16'(v[3] - gyro_bias[0]);
    r.axis[4] = 16'(v[4] - gyro_bias[1]);
    r.axis[5] = 16'(v[5] - gyro_bias[2]);
    r.cal     = bias_locked;
    return r;
  endfunction

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Source: pop pending samples into transactions, in bursts with random gaps.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // Predict at acceptance; the ports still hold the accepted payload.
      if (in_valid && !in_stall) begin
        n_accepted++;
        expected_corrections.push_back(correct_sample(
          {raw_gyro_z, raw_gyro_y, raw_gyro_x, raw_accel_z, raw_accel_y, raw_accel_x}));
      end
      if (in_valid && in_stall) begin
        // Hold the stalled transaction unchanged.
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        nxt = pending_samples.pop_front();
        {raw_gyro_z, raw_gyro_y, raw_gyro_x, raw_accel_z, raw_accel_y, raw_accel_x} <= nxt.axis;
        in_valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        // A third of bursts run straight into the next one.
        if (burst_left == 0) gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: check each result transaction, then pick the next stall value.
  // --------------------------------------------------------------------------
  stall_pattern_t stall_mode = STALL_NONE;
  int             stall_left = 0;
  int             cyc        = 0;

  always @(posedge clk) begin : check_results
    correction_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.axis = {corrected_gyro_z, corrected_gyro_y, corrected_gyro_x,
                  corrected_accel_z, corrected_accel_y, corrected_accel_x};
      got.cal  = is_calibrated;
      if (expected_corrections.size() == 0) begin
        flag($sformatf("unexpected result after %0d checked", n_checked));
      end else begin
        want = expected_corrections.pop_front();
        for (int i = 0; i < 6; i++)
          if (got.axis[i] !== want.axis[i])
            flag($sformatf("result %0d %s: expected %0d, got %0d", n_checked, axis_label[i],
                           $signed(want.axis[i]), $signed(got.axis[i])));
        if (got.cal !== want.cal)
          flag($sformatf("result %0d is_calibrated: expected %0b, got %0b", n_checked,
                         want.cal, got.cal));
        n_checked++;
      end
    end
    // Pick a new stall pattern and a random run length when the current run ends.
    if (stall_left == 0) begin
      stall_mode = stall_pattern_t'($urandom_range(3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    cyc++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(9) < 7);
      default:     out_stall <= (cyc % 5 < 2);
    endcase
  end

  // --------------------------------------------------------------------------
  // Stimulus generation. gen_gyro mirrors the gyro of the last queued sample,
  // so still runs and breaks are built against what the block will compare.
  // --------------------------------------------------------------------------
  int gen_gyro [3] = '{0, 0, 0};
  int gen_thr      = THRESHOLD_RST;

  function automatic int rand_full();
    return $signed(16'($urandom));
  endfunction

  function automatic int rand_span(input int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic int clamp16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  task automatic queue_sample(input int ax, input int ay, input int az,
                              input int gx, input int gy, input int gz);
    sample_t s;
    s.axis = {16'(gz), 16'(gy), 16'(gx), 16'(az), 16'(ay), 16'(ax)};
    pending_samples.push_back(s);
    gen_gyro[0] = gx;
    gen_gyro[1] = gy;
    gen_gyro[2] = gz;
  endtask

  // Gyro wanders strictly inside the threshold; accel scatters around a base.
  task automatic queue_still_run(input int n, input int spread);
    int base [3];
    int g [3];
    for (int i = 0; i < 3; i++) base[i] = rand_span(8000);
    repeat (n) begin
      for (int i = 0; i < 3; i++) g[i] = clamp16(gen_gyro[i] + rand_span(gen_thr - 1));
      queue_sample(clamp16(base[0] + rand_span(spread)), clamp16(base[1] + rand_span(spread)),
                   clamp16(base[2] + rand_span(spread)), g[0], g[1], g[2]);
    end
  endtask

  // Move one gyro axis by at least the threshold, often by exactly it.
  task automatic queue_break();
    int g [3];
    int k, step;
    for (int i = 0; i < 3; i++) g[i] = clamp16(gen_gyro[i] + rand_span(gen_thr - 1));
    k    = $urandom_range(2);
    step = gen_thr + (($urandom_range(1) == 0) ? 0 : int'($urandom_range(300)));
    g[k] = (gen_gyro[k] >= 0) ? gen_gyro[k] - step : gen_gyro[k] + step;
    queue_sample(rand_full(), rand_full(), rand_full(), g[0], g[1], g[2]);
  endtask

  task automatic queue_noise(input int n);
    repeat (n) queue_sample(rand_full(), rand_full(), rand_full(),
                            rand_full(), rand_full(), rand_full());
  endtask

  // Hold until the source is empty and every correction is back.
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid) @(negedge clk);
    while (expected_corrections.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (expected_corrections.size() != 0) begin
      flag($sformatf("%0d results never arrived", expected_corrections.size()));
      expected_corrections.delete();
    end
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STILL_THRESHOLD: thr_model = val;
      REG_GRAVITY_COUNTS:  grav_model = val[GRAV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Registers change only with the pipe drained.
  task automatic reconfigure(input int thr, input int grav);
    wait_idle();
    write_reg(REG_STILL_THRESHOLD, 16'(thr));
    write_reg(REG_GRAVITY_COUNTS, 16'(grav));
    gen_thr = thr;
  endtask

  initial begin
    int thr;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset register values. First sample compares against zero gyro.
    queue_sample(-32768, 32767, 0, 0, 0, 0);
    // Gyro just inside the window; accel z wraps once gravity is added.
    queue_sample(32767, -32768, 32767, 49, -49, 0);
    // Gyro x moves by exactly the threshold: the run clears.
    queue_sample(0, 0, -32768, 99, -49, 0);
    queue_sample(-1, 1, -1, -32768, -32768, -32768);
    // Full-scale gyro swing.
    queue_sample(1, -1, 1, 32767, 32767, 32767);
    queue_sample(21845, -21846, -21846, 32767, 32767, 32766);
    queue_sample(-21846, 21845, 21845, 32718, 32767, 32766);

    // Threshold zero: even an unchanged gyro is motion. Gravity off.
    reconfigure(0, 0);
    queue_sample(100, 200, 300, 32718, 32767, 32766);
    queue_sample(-100, -200, -300, 32718, 32767, 32766);
    queue_sample(0, 0, 0, 32718, 32767, 32766);

    // Widest window; the top bit of the gravity write is dropped.
    reconfigure('hFFFF, 'hFFFF);
    queue_sample(32767, 32767, 32767, -32768, -32768, -32768);
    queue_sample(-32768, -32768, -32768, 32766, 32766, 32766);
    queue_sample(32767, -32768, 0, -32768, -32768, 32767);
    queue_sample(-32768, 32767, -1, 32767, 32767, 32767);

    // Threshold of one: only a frozen gyro counts as still.
    reconfigure(1, $urandom_range(32767));
    repeat (3) begin
      queue_still_run($urandom_range(10, 100), $urandom_range(100, 40000));
      queue_break();
      queue_noise($urandom_range(1, 3));
    end

    // Random window, broken runs, then one that stops a single sample short.
    thr = $urandom_range(2, 4000);
    reconfigure(thr, $urandom_range(32767));
    repeat (3) begin
      queue_still_run($urandom_range(30, 200), $urandom_range(0, 40000));
      queue_break();
      queue_noise($urandom_range(1, 3));
    end
    queue_break();
    queue_still_run(STILL_N - 1, 2000);
    queue_break();
    queue_noise(2);

    // Locking run at reset values; samples past the lock leave offsets frozen.
    reconfigure(THRESHOLD_RST, GRAVITY_RST);
    queue_break();
    queue_still_run(STILL_N + 30, 600);
    queue_noise(20);

    // Calibrated: the threshold no longer matters, gravity still does.
    reconfigure($urandom_range(65535), 'h8000);
    queue_sample(32767, 32767, 32767, 32767, 32767, 32767);
    queue_sample(-32768, -32768, -32768, -32768, -32768, -32768);
    queue_noise(120);

    reconfigure(0, 32767);
    queue_noise(120);

    reconfigure($urandom_range(1, 65535), $urandom_range(32767));
    queue_still_run(60, 3000);
    queue_noise(60);

    wait_idle();
    $display("%0d samples through, %0d corrections compared, %0d failures",
             n_accepted, n_checked, fail_count);
    $display("bias locked at sample %0d; threshold swept 0..65535, gravity 0..32767",
             lock_sample);
    if (fail_count == 0) begin
      $display("imu_stillness_bias_calibration: match");
    end else begin
      $display("imu_stillness_bias_calibration: mismatch");
    end
    $finish;
  end

  // Watchdog: end the run if it has not finished by TIMEOUT_NS.
  initial begin
    #(TIMEOUT_NS);
    $display("watchdog expired with %0d corrections outstanding", expected_corrections.size());
    $display("imu_stillness_bias_calibration: mismatch");
    $finish;
  end

endmodule
